[src/spimds_pkg.sv]
// Shared types, constants and codes of the SPI master with device select.
package spimds_pkg;

   // Field widths of the item channels
   localparam int OP_W     = 3;
   localparam int ID_W     = 8;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int MODE_W   = 2;

   // Bit counter across one byte
   localparam int CNT_W = $clog2(BYTE_W);

   // Device table size and slot index width
   localparam int DEVICE_SLOTS = 4;
   localparam int SLOT_W       = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // Fixed values
   localparam logic [ID_W-1:0]   NO_DEVICE  = 8'hFF;
   localparam logic [BYTE_W-1:0] AUTO_DELAY = 8'd2;
   localparam logic [BYTE_W-1:0] HOLD_TICKS = 8'd2;
   localparam logic [BYTE_W-1:0] NO_TICKS   = 8'd0;

   // Operation codes
   localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
   localparam logic [OP_W-1:0] OP_SELECT   = 3'd1;
   localparam logic [OP_W-1:0] OP_DESELECT = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ     = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

   // Control sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CMD,
      SEQ_SELECT,
      SEQ_XFER
   } seq_state_type;

   // Command to the device table
   typedef struct packed {
      logic              add;
      logic [ID_W-1:0]   id;
      logic [BYTE_W-1:0] delay;
   } tbl_cmd_type;

   // Answers of the device table for the current id
   typedef struct packed {
      logic                found;
      logic [BYTE_W-1:0]   found_delay;
      logic [STATUS_W-1:0] add_status;
   } tbl_stat_type;

   // Control of the bit shifter
   typedef struct packed {
      logic load;
      logic is_read;
      logic step;
      logic cpha;
      logic set_idle;
      logic idle_level;
   } shift_ctrl_type;

   // Line levels and progress of the bit shifter
   typedef struct packed {
      logic              sclk;
      logic              mosi;
      logic              last_edge;
      logic [BYTE_W-1:0] rx_data;
   } shift_stat_type;

endpackage

[src/spimds_if.sv]
// Valid/ready channel interfaces for requests and results.
interface spimds_req_if;
   logic                             valid;
   logic                             ready;
   logic [spimds_pkg::OP_W-1:0]      op;
   logic [spimds_pkg::ID_W-1:0]      dev_id;
   logic [spimds_pkg::BYTE_W-1:0]    setup_delay;
   logic [spimds_pkg::BYTE_W-1:0]    tx_byte;
   logic [spimds_pkg::BYTE_W-1:0]    miso_bits;

   modport source (output valid, op, dev_id, setup_delay, tx_byte, miso_bits,
                   input ready);
   modport sink (input valid, op, dev_id, setup_delay, tx_byte, miso_bits,
                 output ready);
endinterface

interface spimds_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             sclk;
   logic                             mosi;
   logic                             cs_n;
   logic [spimds_pkg::BYTE_W-1:0]    wait_ticks;
   logic [spimds_pkg::BYTE_W-1:0]    rx_byte;
   logic [spimds_pkg::STATUS_W-1:0]  status;
   logic [spimds_pkg::ID_W-1:0]      active_id;
   logic                             last;

   modport source (output valid, sclk, mosi, cs_n, wait_ticks, rx_byte, status,
                   active_id, last, input ready);
   modport sink (input valid, sclk, mosi, cs_n, wait_ticks, rx_byte, status,
                 active_id, last, output ready);
endinterface

[src/spimds_table.sv]
// Device id table: lookup, first-free registration and stored setup delays.
module spimds_table (
   input  logic                     clock,
   input  logic                     reset,
   input  spimds_pkg::tbl_cmd_type  cmd,
   output spimds_pkg::tbl_stat_type stat
);

   logic [spimds_pkg::ID_W-1:0]   ids_ff    [spimds_pkg::DEVICE_SLOTS];
   logic [spimds_pkg::BYTE_W-1:0] delays_ff [spimds_pkg::DEVICE_SLOTS];

   logic [spimds_pkg::DEVICE_SLOTS-1:0] empty;
   logic [spimds_pkg::DEVICE_SLOTS-1:0] match;
   logic                                stop_found;
   logic [spimds_pkg::SLOT_W-1:0]       stop_idx;
   logic                                hit;
   logic [spimds_pkg::BYTE_W-1:0]       hit_delay;
   logic                                store;

   // Scan the slots in order; the lowest slot that is empty or holds the id wins.
   always_comb begin
      stop_found = 1'b0;
      stop_idx   = '0;
      hit        = 1'b0;
      hit_delay  = spimds_pkg::AUTO_DELAY;
      for (int i = spimds_pkg::DEVICE_SLOTS - 1; i >= 0; i--) begin
         empty[i] = (ids_ff[i] == spimds_pkg::NO_DEVICE);
         match[i] = (ids_ff[i] == cmd.id);
         if (empty[i] || match[i]) begin
            stop_found = 1'b1;
            stop_idx   = spimds_pkg::SLOT_W'(i);
         end
         if (match[i]) begin
            hit       = 1'b1;
            hit_delay = delays_ff[i];
         end
      end
   end

   // Registration outcome and lookup answer.
   always_comb begin
      store = stop_found && empty[stop_idx];
      if (!stop_found) begin
         stat.add_status = spimds_pkg::ST_FULL;
      end else if (empty[stop_idx]) begin
         stat.add_status = spimds_pkg::ST_OK;
      end else begin
         stat.add_status = spimds_pkg::ST_DUP;
      end
      stat.found       = hit;
      stat.found_delay = hit_delay;
   end

   // Slot ids are cleared to empty at reset; delays are only read after a store.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spimds_pkg::DEVICE_SLOTS; i++) begin
            ids_ff[i] <= spimds_pkg::NO_DEVICE;
         end
      end else if (cmd.add && store) begin
         ids_ff[stop_idx] <= cmd.id;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && store) begin
         delays_ff[stop_idx] <= cmd.delay;
      end
   end

endmodule

[src/spimds_shift.sv]
// Bit-serial SPI shifter: drives sclk and mosi one half bit per step and samples miso.
module spimds_shift (
   input  logic                           clock,
   input  logic                           reset,
   input  spimds_pkg::shift_ctrl_type     ctrl,
   input  logic [spimds_pkg::BYTE_W-1:0]  tx_byte,
   input  logic [spimds_pkg::BYTE_W-1:0]  miso_bits,
   output spimds_pkg::shift_stat_type     stat
);

   logic                          sclk_ff,  sclk_in;
   logic                          mosi_ff,  mosi_in;
   logic                          phase_ff, phase_in;
   logic                          read_ff,  read_in;
   logic [spimds_pkg::CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [spimds_pkg::BYTE_W-1:0] tx_ff,    tx_in;
   logic [spimds_pkg::BYTE_W-1:0] miso_ff,  miso_in;
   logic [spimds_pkg::BYTE_W-1:0] acc_ff,   acc_in;
   logic                          shift_now;

   // One half bit per step: the leading edge in phase 0, the trailing edge in phase 1.
   // The receive register only moves on a step, so a received byte that still
   // waits in the result register is not disturbed when the next item loads.
   always_comb begin
      sclk_in   = sclk_ff;
      mosi_in   = mosi_ff;
      phase_in  = phase_ff;
      read_in   = read_ff;
      cnt_in    = cnt_ff;
      tx_in     = tx_ff;
      miso_in   = miso_ff;
      acc_in    = acc_ff;
      shift_now = 1'b0;
      if (ctrl.set_idle) begin
         sclk_in = ctrl.idle_level;
      end
      if (ctrl.load) begin
         phase_in = 1'b0;
         cnt_in   = '0;
         read_in  = ctrl.is_read;
         tx_in    = tx_byte;
         miso_in  = miso_bits;
      end else if (ctrl.step) begin
         sclk_in  = ~sclk_ff;
         phase_in = ~phase_ff;
         // Data changes on the same step as the edge on which the slave samples it.
         if (!read_ff && (phase_ff == ctrl.cpha)) begin
            mosi_in = tx_ff[spimds_pkg::BYTE_W-1];
         end
         // Sample on the leading edge when cpha is clear, else on the trailing one.
         if (read_ff && (phase_ff == ctrl.cpha)) begin
            shift_now = 1'b1;
         end
         if (shift_now) begin
            acc_in = {acc_ff[spimds_pkg::BYTE_W-2:0], miso_ff[spimds_pkg::BYTE_W-1]};
         end
         if (phase_ff) begin
            cnt_in  = cnt_ff + 1'b1;
            tx_in   = {tx_ff[spimds_pkg::BYTE_W-2:0], 1'b0};
            miso_in = {miso_ff[spimds_pkg::BYTE_W-2:0], 1'b0};
         end
      end
   end

   // Line levels and control bits take their reset values; data registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         sclk_ff  <= 1'b0;
         mosi_ff  <= 1'b1;
         phase_ff <= 1'b0;
         read_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         sclk_ff  <= sclk_in;
         mosi_ff  <= mosi_in;
         phase_ff <= phase_in;
         read_ff  <= read_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff   <= tx_in;
      miso_ff <= miso_in;
      acc_ff  <= acc_in;
   end

   // The next step is the final edge of the byte.
   always_comb begin
      stat.sclk      = sclk_ff;
      stat.mosi      = mosi_ff;
      stat.last_edge = phase_ff && (cnt_ff == '1);
      stat.rx_data   = acc_ff;
   end

endmodule

[src/spi_master_with_device_select.sv]
// SPI master for every clock mode (CPOL and CPHA) with a small table of selectable devices.
//
// Requests arrive on req_chan (valid/ready); each item is an operation with
// its arguments. Results leave on rsp_chan (valid/ready), one or more per
// item, the final one marked by last. Every result reports the line levels
// sclk, mosi and cs_n after its event, the active device and a status.
// The mode register (CPOL in bit 1, CPHA in bit 0) is reached at every
// address of the APB-style csr_ port; it is to be written while no item is
// in progress, which the block itself does not enforce. The write also
// returns sclk to the idle level of the new mode. The first result of an
// item is emitted from the command or transfer state entered on acceptance.
// Register, deselect and refused items give one result; select gives one or
// two. A write or read gives sixteen results, one per half bit, stepped by
// the bit-serial shifter. A new item is taken once the previous one has
// produced its final result, even while that result still waits. A stalled
// receiver holds the result register and freezes all progress.
// Reset empties the device table, releases chip select, sets sclk low,
// mosi high and mode 0. Nothing is in flight after reset.
module spi_master_with_device_select (
   input  logic                                clock,
   input  logic                                reset,
   spimds_req_if.sink                          req_chan,
   spimds_rsp_if.source                        rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spimds_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spimds_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spimds_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   spimds_pkg::seq_state_type state_ff, state_in;

   logic [spimds_pkg::MODE_W-1:0]   mode_ff,   mode_in;
   logic                            cs_ff,     cs_in;
   logic [spimds_pkg::ID_W-1:0]     active_ff, active_in;
   logic [spimds_pkg::OP_W-1:0]     op_ff;
   logic [spimds_pkg::ID_W-1:0]     id_ff;
   logic [spimds_pkg::BYTE_W-1:0]   dly_ff;

   logic                            rsp_valid_ff;
   logic [spimds_pkg::BYTE_W-1:0]   wait_ff,    wait_in;
   logic [spimds_pkg::STATUS_W-1:0] status_ff,  status_in;
   logic                            last_ff,    last_in;
   logic                            rx_show_ff, rx_show_in;

   logic emit;
   logic out_free;
   logic req_take;
   logic csr_write;
   logic refused;

   spimds_pkg::tbl_cmd_type    tbl_cmd;
   spimds_pkg::tbl_stat_type   tbl_stat;
   spimds_pkg::shift_ctrl_type sh_ctrl;
   spimds_pkg::shift_stat_type sh_stat;

   // Handshake decode
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == spimds_pkg::SEQ_IDLE);
   assign req_take  = req_chan.valid && req_chan.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(spimds_pkg::CSR_DATA_W - spimds_pkg::MODE_W){1'b0}}, mode_ff};
   assign refused = ((op_ff inside {spimds_pkg::OP_REGISTER, spimds_pkg::OP_SELECT,
                                    spimds_pkg::OP_DESELECT})
                     && (id_ff == spimds_pkg::NO_DEVICE))
                    || !(op_ff inside {[spimds_pkg::OP_REGISTER:spimds_pkg::OP_READ]});

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spimds_pkg::SEQ_IDLE: begin
            if (req_take) begin
               if (req_chan.op inside {spimds_pkg::OP_WRITE, spimds_pkg::OP_READ}) begin
                  state_in = spimds_pkg::SEQ_XFER;
               end else begin
                  state_in = spimds_pkg::SEQ_CMD;
               end
            end
         end
         spimds_pkg::SEQ_CMD: begin
            if (out_free) begin
               if (!refused && (op_ff == spimds_pkg::OP_SELECT)
                   && (active_ff != spimds_pkg::NO_DEVICE)) begin
                  state_in = spimds_pkg::SEQ_SELECT;
               end else begin
                  state_in = spimds_pkg::SEQ_IDLE;
               end
            end
         end
         spimds_pkg::SEQ_SELECT: begin
            if (out_free) begin
               state_in = spimds_pkg::SEQ_IDLE;
            end
         end
         spimds_pkg::SEQ_XFER: begin
            if (out_free && sh_stat.last_edge) begin
               state_in = spimds_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = spimds_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Sequencer outputs: one result per step, with the line state it leaves behind.
   always_comb begin
      emit       = 1'b0;
      wait_in    = spimds_pkg::NO_TICKS;
      status_in  = spimds_pkg::ST_OK;
      last_in    = 1'b1;
      rx_show_in = 1'b0;
      cs_in      = cs_ff;
      active_in  = active_ff;
      mode_in    = mode_ff;
      tbl_cmd.add   = 1'b0;
      tbl_cmd.id    = id_ff;
      tbl_cmd.delay = dly_ff;
      sh_ctrl.load       = req_take;
      sh_ctrl.is_read    = (req_chan.op == spimds_pkg::OP_READ);
      sh_ctrl.step       = 1'b0;
      sh_ctrl.cpha       = mode_ff[0];
      sh_ctrl.set_idle   = csr_write;
      sh_ctrl.idle_level = csr_pwdata[1];
      if (csr_write) begin
         mode_in = csr_pwdata[spimds_pkg::MODE_W-1:0];
      end
      case (state_ff)
         spimds_pkg::SEQ_CMD: begin
            if (out_free) begin
               emit = 1'b1;
               if (refused) begin
                  status_in = spimds_pkg::ST_IGNORED;
               end else begin
                  case (op_ff)
                     spimds_pkg::OP_REGISTER: begin
                        tbl_cmd.add = 1'b1;
                        status_in   = tbl_stat.add_status;
                     end
                     spimds_pkg::OP_SELECT: begin
                        if (active_ff != spimds_pkg::NO_DEVICE) begin
                           // Release the current device first.
                           cs_in     = 1'b1;
                           active_in = spimds_pkg::NO_DEVICE;
                           wait_in   = spimds_pkg::HOLD_TICKS;
                           last_in   = 1'b0;
                        end else begin
                           tbl_cmd.add   = 1'b1;
                           tbl_cmd.delay = spimds_pkg::AUTO_DELAY;
                           cs_in         = 1'b0;
                           active_in     = id_ff;
                           wait_in       = tbl_stat.found ? tbl_stat.found_delay
                                                          : spimds_pkg::AUTO_DELAY;
                        end
                     end
                     spimds_pkg::OP_DESELECT: begin
                        if (active_ff == id_ff) begin
                           cs_in     = 1'b1;
                           active_in = spimds_pkg::NO_DEVICE;
                           wait_in   = spimds_pkg::HOLD_TICKS;
                        end else begin
                           status_in = spimds_pkg::ST_IGNORED;
                        end
                     end
                     default: begin
                        status_in = spimds_pkg::ST_IGNORED;
                     end
                  endcase
               end
            end
         end
         spimds_pkg::SEQ_SELECT: begin
            if (out_free) begin
               // Unknown ids are registered with the automatic delay.
               emit          = 1'b1;
               tbl_cmd.add   = 1'b1;
               tbl_cmd.delay = spimds_pkg::AUTO_DELAY;
               cs_in         = 1'b0;
               active_in     = id_ff;
               wait_in       = tbl_stat.found ? tbl_stat.found_delay : spimds_pkg::AUTO_DELAY;
            end
         end
         spimds_pkg::SEQ_XFER: begin
            if (out_free) begin
               emit         = 1'b1;
               sh_ctrl.step = 1'b1;
               last_in      = sh_stat.last_edge;
               rx_show_in   = sh_stat.last_edge && (op_ff == spimds_pkg::OP_READ);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spimds_pkg::SEQ_IDLE;
         mode_ff      <= '0;
         cs_ff        <= 1'b1;
         active_ff    <= spimds_pkg::NO_DEVICE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         cs_ff     <= cs_in;
         active_ff <= active_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item arguments and result fields
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_chan.op;
         id_ff  <= req_chan.dev_id;
         dly_ff <= req_chan.setup_delay;
      end
      if (emit) begin
         wait_ff    <= wait_in;
         status_ff  <= status_in;
         last_ff    <= last_in;
         rx_show_ff <= rx_show_in;
      end
   end

   spimds_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .stat  (tbl_stat)
   );

   spimds_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sh_ctrl),
      .tx_byte   (req_chan.tx_byte),
      .miso_bits (req_chan.miso_bits),
      .stat      (sh_stat)
   );

   // Line state moves only when a result is produced or the mode is written, so it matches the pending result.
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sclk       = sh_stat.sclk;
   assign rsp_chan.mosi       = sh_stat.mosi;
   assign rsp_chan.cs_n       = cs_ff;
   assign rsp_chan.wait_ticks = wait_ff;
   assign rsp_chan.rx_byte    = rx_show_ff ? sh_stat.rx_data : '0;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.active_id  = active_ff;
   assign rsp_chan.last       = last_ff;

`ifndef SYNTHESIS
   // Chip select is low exactly while a device is active.
   a_cs_tracks_active: assert property (@(posedge clock) disable iff (reset)
      (cs_ff == 1'b0) == (active_ff != spimds_pkg::NO_DEVICE))
      else $error("chip select disagrees with active device");

   // Between items the serial clock rests at the idle level of the mode.
   a_sclk_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spimds_pkg::SEQ_IDLE) |-> (sh_stat.sclk == mode_ff[1]))
      else $error("serial clock not at idle level between items");

   // Received data is only shown on the final result of an item.
   a_rx_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rx_show_ff) |-> last_ff)
      else $error("received byte shown on a result that is not the last");
`endif

endmodule
